### rtl/aging_wildcard_flow_table_core_macros.svh
// Assertion helpers shared by the flow table RTL.
// All properties are sampled on the rising edge of clk and are held off during reset.
`ifndef AGING_WILDCARD_FLOW_TABLE_CORE_MACROS_SVH
`define AGING_WILDCARD_FLOW_TABLE_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Plain property that must hold at every edge out of reset.
`define AWFT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition in one cycle implies a consequence in the next.
`define AWFT_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define AWFT_ASSERT(label, prop, msg)
`define AWFT_ASSERT_NEXT(label, pre, post, msg)
`endif

`endif

### rtl/awft_pkg.sv
package awft_pkg;

    // Ring geometry
    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Expiry register
    localparam int                EXPIRE_W     = 15;
    localparam logic [EXPIRE_W-1:0] EXPIRE_RESET = EXPIRE_W'(5);

    // Operation codes
    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_CHECK = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    // Query fields as presented on a check
    typedef struct packed {
        logic [31:0] source_address;
        logic [31:0] dest_address;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [15:0] query_id;
    } query_t;

    // One stored tag: flow fields plus the seconds stamp, 128 bits
    typedef struct packed {
        query_t      flow;
        logic [15:0] stamp;
    } tag_t;

    // Compare unit status toward the sequencer
    typedef struct packed {
        logic expired;
        logic hit;
    } awft_status_t;

    // Advance a ring index with wrap at the table depth
    function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
        if (idx == IDX_W'(TABLE_DEPTH - 1))
        begin
            return '0;
        end
        return idx + 1'b1;
    endfunction

endpackage

### rtl/aging_wildcard_flow_table_core.sv
// Aging flow table: a 16-entry insertion-ordered ring of flow tags, each stamped with a 16-bit
// seconds count. An add, a tick or an unused code is accepted and then presents its result. A
// check is accepted, then removes expired tags from the head one per cycle, then compares the
// remaining tags one per cycle up to a hit or the tail, then presents its result; the tags removed
// and the tags compared together never exceed the 16 stored tags. The tag memory has a single read
// port feeding one compare unit, one tag per cycle. Items are taken one at a time: in_ready is low
// from acceptance until the result has been taken from the output register. The expiry register
// is written through cfg_valid/cfg_data only while idle.
`include "aging_wildcard_flow_table_core_macros.svh"

module aging_wildcard_flow_table_core
    import awft_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // input transactions
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          operation,
    input  logic [31:0]         source_address,
    input  logic [31:0]         dest_address,
    input  logic [15:0]         source_port,
    input  logic [15:0]         dest_port,
    input  logic [15:0]         query_id,
    // result transactions
    output logic                out_valid,
    input  logic                out_ready,
    output logic                found,
    output logic                dropped,
    // configuration
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [EXPIRE_W-1:0] cfg_data
);

    // Sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXP  = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_RESP = 2'd3;

    logic [1:0]          state_reg,     state_next;
    logic [IDX_W-1:0]    head_reg,      head_next;
    logic [IDX_W-1:0]    tail_reg,      tail_next;
    logic [CNT_W-1:0]    count_reg,     count_next;
    logic [15:0]         seconds_reg,   seconds_next;
    logic [EXPIRE_W-1:0] expire_reg,    expire_next;
    logic [IDX_W-1:0]    scan_ptr_reg,  scan_ptr_next;
    logic [CNT_W-1:0]    scan_left_reg, scan_left_next;
    logic                found_reg,     found_next;
    logic                dropped_reg,   dropped_next;
    query_t              query_reg,     query_next;

    tag_t                mem [TABLE_DEPTH];
    tag_t                rd_data_reg;
    logic                wr_en;
    tag_t                wr_data;
    logic                in_fire;
    awft_status_t        status;

    assign in_fire   = in_valid && in_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_RESP);
    assign found     = found_reg;
    assign dropped   = dropped_reg;
    assign cfg_ready = (state_reg == ST_IDLE);

    // Compare unit on the registered memory read
    awft_match u_match (
        .tag            (rd_data_reg),
        .query          (query_reg),
        .seconds_now    (seconds_reg),
        .expire_seconds (expire_reg),
        .status         (status)
    );

    // Tag memory: one write port at the tail, one registered read at the scan pointer
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[tail_reg] <= wr_data;
        end
        rd_data_reg <= mem[scan_ptr_next];
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        seconds_next   = seconds_reg;
        expire_next    = expire_reg;
        scan_ptr_next  = scan_ptr_reg;
        scan_left_next = scan_left_reg;
        found_next     = found_reg;
        dropped_next   = dropped_reg;
        query_next     = query_reg;
        wr_en          = 1'b0;
        wr_data.flow.source_address = source_address;
        wr_data.flow.dest_address   = dest_address;
        wr_data.flow.source_port    = source_port;
        wr_data.flow.dest_port      = dest_port;
        wr_data.flow.query_id       = query_id;
        wr_data.stamp               = seconds_reg;

        if (cfg_valid && cfg_ready)
        begin
            expire_next = cfg_data;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    found_next   = 1'b0;
                    dropped_next = 1'b0;
                    state_next   = ST_RESP;
                    unique case (operation)
                        OP_ADD:
                        begin
                            if (count_reg == CNT_W'(TABLE_DEPTH))
                            begin
                                dropped_next = 1'b1;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                tail_next  = ring_next(tail_reg);
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_CHECK:
                        begin
                            query_next    = wr_data.flow;
                            scan_ptr_next = head_reg;
                            state_next    = ST_EXP;
                        end
                        OP_TICK:
                        begin
                            seconds_next = seconds_reg + 1'b1;
                        end
                        default:
                        begin
                            // unused code: empty result only
                        end
                    endcase
                end
            end
            ST_EXP:
            begin
                // drop expired tags from the head, one per cycle
                if (count_reg == '0)
                begin
                    state_next = ST_RESP;
                end
                else if (status.expired)
                begin
                    head_next     = ring_next(head_reg);
                    scan_ptr_next = ring_next(head_reg);
                    count_next    = count_reg - 1'b1;
                end
                else
                begin
                    scan_left_next = count_reg;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // walk the live tags until a hit or the tail
                if (status.hit)
                begin
                    found_next = 1'b1;
                    state_next = ST_RESP;
                end
                else if (scan_left_reg == CNT_W'(1))
                begin
                    state_next = ST_RESP;
                end
                else
                begin
                    scan_ptr_next  = ring_next(scan_ptr_reg);
                    scan_left_next = scan_left_reg - 1'b1;
                end
            end
            ST_RESP:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            seconds_reg   <= '0;
            expire_reg    <= EXPIRE_RESET;
            scan_ptr_reg  <= '0;
            scan_left_reg <= '0;
            found_reg     <= 1'b0;
            dropped_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            seconds_reg   <= seconds_next;
            expire_reg    <= expire_next;
            scan_ptr_reg  <= scan_ptr_next;
            scan_left_reg <= scan_left_next;
            found_reg     <= found_next;
            dropped_reg   <= dropped_next;
        end
    end

    // Query payload, loaded when a check is accepted
    always_ff @(posedge clk)
    begin
        query_reg <= query_next;
    end

    // Checks
    `AWFT_ASSERT(a_count_bound, count_reg <= CNT_W'(TABLE_DEPTH), "entry count above depth")
    `AWFT_ASSERT(a_one_side, !(in_ready && out_valid), "input taken while result pending")
    `AWFT_ASSERT(a_flags_excl, !out_valid || !(found_reg && dropped_reg), "found and dropped both set")
    `AWFT_ASSERT_NEXT(a_add_grows, in_fire && operation == OP_ADD && count_reg != CNT_W'(TABLE_DEPTH), count_reg == $past(count_reg) + 1'b1, "add did not grow the ring")
    `AWFT_ASSERT_NEXT(a_exp_shrinks, state_reg == ST_EXP || state_reg == ST_SCAN, count_reg <= $past(count_reg), "ring grew during a check")

endmodule

### rtl/awft_match.sv
// Shared compare unit: judges one stored tag per cycle for age and for a wildcard match.
module awft_match
    import awft_pkg::*;
(
    input  tag_t                tag,
    input  query_t              query,
    input  logic [15:0]         seconds_now,
    input  logic [EXPIRE_W-1:0] expire_seconds,
    output awft_status_t        status
);

    logic [15:0] age;
    logic        sa_ok;
    logic        da_ok;
    logic        sp_ok;
    logic        dp_ok;
    logic        qi_ok;

    // Modular age against the expiry limit
    assign age            = seconds_now - tag.stamp;
    assign status.expired = (age >= {1'b0, expire_seconds});

    // Zero in a query field matches anything
    assign sa_ok = (query.source_address == '0) ||
                   (query.source_address == tag.flow.source_address);
    assign da_ok = (query.dest_address == '0) ||
                   (query.dest_address == tag.flow.dest_address);
    assign sp_ok = (query.source_port == '0) || (query.source_port == tag.flow.source_port);
    assign dp_ok = (query.dest_port == '0) || (query.dest_port == tag.flow.dest_port);
    assign qi_ok = (query.query_id == '0) || (query.query_id == tag.flow.query_id);

    assign status.hit = sa_ok && da_ok && sp_ok && dp_ok && qi_ok;

endmodule

### bench/tb_aging_wildcard_flow_table_core.sv
`timescale 1ns / 100ps

module tb_aging_wildcard_flow_table_core
    import awft_pkg::*;
;

    localparam logic [1:0] OP_SPARE       = 2'd3;
    localparam int         PHASE_ITEMS    = 180;
    localparam int         WATCHDOG_LIMIT = 4000;
    localparam int         REPORT_LIMIT   = 10;

    typedef struct packed {
        logic [1:0] op;
        query_t     flow;
        logic       drain;   // hold off until every outstanding verdict is back
    } flow_item_t;

    typedef struct packed {
        logic found;
        logic dropped;
    } flow_result_t;

    // DUT connections
    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [1:0]          operation = OP_ADD;
    logic [31:0]         source_address = '0;
    logic [31:0]         dest_address = '0;
    logic [15:0]         source_port = '0;
    logic [15:0]         dest_port = '0;
    logic [15:0]         query_id = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic                found;
    logic                dropped;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [EXPIRE_W-1:0] cfg_data = EXPIRE_RESET;

    // Stimulus and scoreboard storage
    flow_item_t   flow_cmd_q[$];
    flow_result_t verdict_q[$];
    query_t       recent_flows[$];
    logic         in_taken = 1'b0;
    bit           free_run = 1'b0;
    int           mismatch_count = 0;
    int           stall_cycles = 0;

    // Shadow of the flow table
    tag_t                flow_ring [TABLE_DEPTH];
    logic [IDX_W-1:0]    ring_head = '0;
    logic [IDX_W-1:0]    ring_tail = '0;
    logic [CNT_W-1:0]    ring_fill = '0;
    logic [15:0]         sec_count = '0;
    logic [EXPIRE_W-1:0] expire_limit = EXPIRE_RESET;

    aging_wildcard_flow_table_core u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .operation      (operation),
        .source_address (source_address),
        .dest_address   (dest_address),
        .source_port    (source_port),
        .dest_port      (dest_port),
        .query_id       (query_id),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .found          (found),
        .dropped        (dropped),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [IDX_W-1:0] ring_step(input logic [IDX_W-1:0] idx);
        return (idx == IDX_W'(TABLE_DEPTH - 1)) ? '0 : idx + 1'b1;
    endfunction

    // Advance the shadow table by one transaction and return the verdict it yields
    function automatic flow_result_t predict_flow_verdict(input flow_item_t cmd);
        flow_result_t verdict;
        query_t       stored;
        logic [IDX_W-1:0] probe;
        int           k;
        verdict = '0;
        case (cmd.op)
            OP_ADD:
            begin
                if (ring_fill == CNT_W'(TABLE_DEPTH))
                begin
                    verdict.dropped = 1'b1;
                end
                else
                begin
                    flow_ring[ring_tail].flow  = cmd.flow;
                    flow_ring[ring_tail].stamp = sec_count;
                    ring_tail = ring_step(ring_tail);
                    ring_fill = ring_fill + 1'b1;
                end
            end
            OP_CHECK:
            begin
                // age out from the oldest end first
                while (ring_fill != 0 &&
                       16'(sec_count - flow_ring[ring_head].stamp) >= {1'b0, expire_limit})
                begin
                    ring_head = ring_step(ring_head);
                    ring_fill = ring_fill - 1'b1;
                end
                // zero in a query field is a wildcard
                probe = ring_head;
                for (k = 0; k < ring_fill; k++)
                begin
                    stored = flow_ring[probe].flow;
                    if ((cmd.flow.source_address == 0 ||
                         cmd.flow.source_address == stored.source_address) &&
                        (cmd.flow.dest_address == 0 ||
                         cmd.flow.dest_address == stored.dest_address) &&
                        (cmd.flow.source_port == 0 ||
                         cmd.flow.source_port == stored.source_port) &&
                        (cmd.flow.dest_port == 0 ||
                         cmd.flow.dest_port == stored.dest_port) &&
                        (cmd.flow.query_id == 0 ||
                         cmd.flow.query_id == stored.query_id))
                    begin
                        verdict.found = 1'b1;
                    end
                    probe = ring_step(probe);
                end
            end
            OP_TICK:
            begin
                sec_count = sec_count + 1'b1;
            end
            default:
            begin
            end
        endcase
        return verdict;
    endfunction

    // Field values biased toward all-zero, all-one and small numbers
    function automatic logic [31:0] rand_addr();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return 32'($urandom_range(3));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] rand_port();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return 16'($urandom_range(3));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic query_t random_flow();
        query_t q;
        q.source_address = rand_addr();
        q.dest_address   = rand_addr();
        q.source_port    = rand_port();
        q.dest_port      = rand_port();
        q.query_id       = rand_port();
        return q;
    endfunction

    function automatic void queue_cmd(input logic [1:0] op, input query_t flow, input bit drain);
        flow_item_t cmd;
        cmd.op    = op;
        cmd.flow  = flow;
        cmd.drain = drain;
        flow_cmd_q.push_back(cmd);
        // remember what went in so later checks can hit it
        if (op == OP_ADD)
        begin
            recent_flows.push_back(flow);
            if (recent_flows.size() > 24)
            begin
                void'(recent_flows.pop_front());
            end
        end
    endfunction

    // Block is idle once nothing is queued, presented or outstanding
    task automatic wait_quiet();
        @(negedge clk);
        while (flow_cmd_q.size() != 0 || in_valid || verdict_q.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic write_expire(input logic [EXPIRE_W-1:0] limit);
        wait_quiet();
        cfg_data  <= limit;
        cfg_valid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // One random phase under a fixed expiry setting
    task automatic run_phase(input logic [EXPIRE_W-1:0] limit, input int add_pct, input bit quiet);
        query_t q;
        int     pick;
        int     n;
        write_expire(limit);
        free_run = quiet;
        for (n = 0; n < PHASE_ITEMS; n++)
        begin
            pick = $urandom_range(99);
            if (pick < add_pct)
            begin
                queue_cmd(OP_ADD, random_flow(), $urandom_range(49) == 0);
            end
            else if (pick < add_pct + 35)
            begin
                if (recent_flows.size() != 0 && $urandom_range(9) < 7)
                begin
                    q = recent_flows[$urandom_range(recent_flows.size() - 1)];
                    if ($urandom_range(99) < 35) q.source_address = '0;
                    if ($urandom_range(99) < 35) q.dest_address = '0;
                    if ($urandom_range(99) < 35) q.source_port = '0;
                    if ($urandom_range(99) < 35) q.dest_port = '0;
                    if ($urandom_range(99) < 35) q.query_id = '0;
                    // near miss on one field
                    if ($urandom_range(99) < 15)
                    begin
                        case ($urandom_range(4))
                            0:       q.source_address ^= 32'h1;
                            1:       q.dest_address ^= 32'h8000_0000;
                            2:       q.source_port ^= 16'h1;
                            3:       q.dest_port ^= 16'h8000;
                            default: q.query_id ^= 16'h1;
                        endcase
                    end
                end
                else
                begin
                    q = random_flow();
                end
                queue_cmd(OP_CHECK, q, $urandom_range(49) == 0);
            end
            else if (pick < 97)
            begin
                queue_cmd(OP_TICK, random_flow(), 1'b0);
            end
            else
            begin
                queue_cmd(OP_SPARE, random_flow(), 1'b0);
            end
        end
    endtask

    // Input driver and result-side backpressure, both on the falling edge
    always @(negedge clk)
    begin
        flow_item_t cmd;
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= free_run || ($urandom_range(99) >= 31);
            if (!in_valid || in_taken)
            begin
                if (flow_cmd_q.size() != 0 && (free_run || $urandom_range(99) >= 31) &&
                    !(flow_cmd_q[0].drain && verdict_q.size() != 0))
                begin
                    cmd = flow_cmd_q.pop_front();
                    in_valid       <= 1'b1;
                    operation      <= cmd.op;
                    source_address <= cmd.flow.source_address;
                    dest_address   <= cmd.flow.dest_address;
                    source_port    <= cmd.flow.source_port;
                    dest_port      <= cmd.flow.dest_port;
                    query_id       <= cmd.flow.query_id;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check results, track config writes, predict accepted transactions
    always @(posedge clk)
    begin
        flow_item_t   seen;
        flow_result_t want;
        in_taken <= rst_n && in_valid && in_ready;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (verdict_q.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                    begin
                        $display("%0t: unexpected result found=%b dropped=%b",
                                 $realtime, found, dropped);
                    end
                end
                else
                begin
                    want = verdict_q.pop_front();
                    if (found !== want.found || dropped !== want.dropped)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                        begin
                            $display("%0t: mismatch found exp %b got %b, dropped exp %b got %b",
                                     $realtime, want.found, found, want.dropped, dropped);
                        end
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                expire_limit = cfg_data;
            end
            if (in_valid && in_ready)
            begin
                seen.op                  = operation;
                seen.flow.source_address = source_address;
                seen.flow.dest_address   = dest_address;
                seen.flow.source_port    = source_port;
                seen.flow.dest_port      = dest_port;
                seen.flow.query_id       = query_id;
                seen.drain               = 1'b0;
                verdict_q.push_back(predict_flow_verdict(seen));
            end
        end
    end

    // Watchdog: no transaction on any channel for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired, %0d verdicts outstanding",
                     $realtime, verdict_q.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Stimulus sequence
    initial
    begin
        query_t q;
        query_t ones;
        int     i;
        ones = '1;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty ring, extreme field values, wildcards, spare opcode, full ring
        queue_cmd(OP_CHECK, '0, 1'b0);
        queue_cmd(OP_ADD, '0, 1'b0);
        queue_cmd(OP_ADD, ones, 1'b0);
        queue_cmd(OP_CHECK, '0, 1'b0);
        queue_cmd(OP_CHECK, ones, 1'b0);
        q = '0;
        q.source_port = 16'hFFFE;
        queue_cmd(OP_CHECK, q, 1'b0);
        queue_cmd(OP_SPARE, ones, 1'b0);
        queue_cmd(OP_TICK, ones, 1'b0);
        for (i = 0; i < TABLE_DEPTH - 2; i++)
        begin
            q = random_flow();
            queue_cmd(OP_ADD, q, 1'b0);
        end
        queue_cmd(OP_ADD, random_flow(), 1'b0);
        queue_cmd(OP_CHECK, q, 1'b1);
        // zero expiry flushes everything
        write_expire('0);
        queue_cmd(OP_CHECK, '0, 1'b0);

        // Largest expiry keeps a tag, then aging right at the boundary
        write_expire('1);
        free_run = 1'b1;
        q = random_flow();
        queue_cmd(OP_ADD, q, 1'b0);
        repeat (6) queue_cmd(OP_TICK, '0, 1'b0);
        queue_cmd(OP_CHECK, q, 1'b0);
        write_expire(EXPIRE_W'(7));
        queue_cmd(OP_CHECK, q, 1'b0);
        queue_cmd(OP_TICK, '0, 1'b0);
        queue_cmd(OP_CHECK, q, 1'b0);
        write_expire(EXPIRE_W'(5));
        queue_cmd(OP_CHECK, q, 1'b0);
        free_run = 1'b0;

        // Random phases under several expiry settings
        run_phase(EXPIRE_W'(3), 40, 1'b0);
        run_phase(EXPIRE_W'(1), 30, 1'b0);
        run_phase(EXPIRE_W'(8), 50, 1'b0);
        run_phase(EXPIRE_W'(16), 45, 1'b1);
        run_phase(EXPIRE_W'(2), 30, 1'b0);
        run_phase(EXPIRE_W'($urandom_range(12)), 40, 1'b0);

        wait_quiet();
        repeat (60) @(posedge clk);
        if (mismatch_count == 0 && verdict_q.size() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            if (verdict_q.size() != 0)
            begin
                $display("%0d verdicts never arrived", verdict_q.size());
            end
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
